@@ rtl/core/rptw_pkg.sv @@
// ----------------------------------------------------------------------------
// rptw_pkg
// Shared types and constants for the radix page table walker: controller
// states, configuration register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package rptw_pkg;

    // Fixed field widths
    localparam int VA_W        = 32;
    localparam int CNT_W       = 32;
    localparam int OFF_W       = 6;
    localparam int FRAME_OUT_W = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int LC_W        = 2;
    localparam int LB_W        = 4;
    localparam int FL_W        = 16;
    localparam int CFG_LEVELS  = 3;

    // Default parameter values
    localparam int DEF_MAX_LEVELS     = 3;
    localparam int DEF_MAX_LEVEL_BITS = 8;
    localparam int DEF_NODE_POOL      = 64;
    localparam int DEF_FRAME_BITS     = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_ZERO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_ONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_TWO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 3'd4;

    // Configuration reset values
    localparam logic [LC_W-1:0] RST_LEVEL_COUNT = 2'd2;
    localparam logic [LB_W-1:0] RST_LEVEL_BITS  = 4'd8;
    localparam logic [FL_W-1:0] RST_FRAME_LIMIT = 16'hFFFF;

    // Walk controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_WRITE,
        ST_RESULT
    } state_t;

endpackage

@@ rtl/core/rptw_split.sv @@
// ----------------------------------------------------------------------------
// rptw_split
// Splits a virtual address into per-level table indexes and an offset width,
// with level count and level widths clamped to the configurable range.
// ----------------------------------------------------------------------------
module rptw_split #(
    parameter int LEVELS         = rptw_pkg::CFG_LEVELS,
    parameter int MAX_LEVEL_BITS = rptw_pkg::DEF_MAX_LEVEL_BITS
) (
    input  logic [rptw_pkg::VA_W-1:0]                     va,
    input  logic [rptw_pkg::LC_W-1:0]                     level_count,
    input  logic [rptw_pkg::CFG_LEVELS-1:0][rptw_pkg::LB_W-1:0] level_bits,
    output logic [LEVELS-1:0][MAX_LEVEL_BITS-1:0]         idx,
    output logic [rptw_pkg::OFF_W-1:0]                    offset,
    output logic [$clog2(LEVELS+1)-1:0]                   n
);

    localparam int LVL_W = $clog2(LEVELS + 1);
    localparam int OFF_W = rptw_pkg::OFF_W;

    always_comb
    begin
        logic [OFF_W-1:0] remaining;
        logic [OFF_W-1:0] cfg_b;
        logic [OFF_W-1:0] b;

        if (level_count == '0)
        begin
            n = LVL_W'(1);
        end
        else if ({1'b0, level_count} > 3'(LEVELS))
        begin
            n = LVL_W'(LEVELS);
        end
        else
        begin
            n = LVL_W'(level_count);
        end

        // Take index fields from the top of the address down
        remaining = OFF_W'(rptw_pkg::VA_W);
        for (int i = 0; i < LEVELS; i++)
        begin
            cfg_b = OFF_W'(level_bits[i]);
            if (cfg_b == '0)
            begin
                b = OFF_W'(1);
            end
            else if (cfg_b > OFF_W'(MAX_LEVEL_BITS))
            begin
                b = OFF_W'(MAX_LEVEL_BITS);
            end
            else
            begin
                b = cfg_b;
            end
            if (b > remaining)
            begin
                b = remaining;
            end
            idx[i] = '0;
            if (i < int'(n))
            begin
                remaining = remaining - b;
                idx[i]    = MAX_LEVEL_BITS'(va >> remaining)
                            & ~({MAX_LEVEL_BITS{1'b1}} << b);
            end
        end
        offset = remaining;
    end

endmodule

@@ rtl/core/radix_page_table_walker.sv @@
// ----------------------------------------------------------------------------
// radix_page_table_walker
// Walks a multi-level radix page table held in one entry store. Hits return
// the stored frame; misses map the page to the next free frame, taking
// interior nodes from a bounded pool, unless frames or pool nodes run out.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-------------------------------------
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in       | in_valid / in_stall    | virtual_address
//  out      | out_valid / out_stall  | hit, inserted, frames_exhausted,
//           |                        | pool_full, frame_number,
//           |                        | physical_address, hit_count,
//           |                        | fault_count
//
//  Each item is walked to its result before the next address is accepted.
//  Each level read passes through a read state and an evaluate state because
//  the store has a registered read port and the next address depends on the
//  data. After reset all NODE_POOL << MAX_LEVEL_BITS entries of the store
//  (16384 with default parameters) are swept clear, and no item is accepted
//  until the sweep ends.
//  A result held by out_stall keeps the walker from posting the next result.
//
module radix_page_table_walker #(
    parameter int MAX_LEVELS     = rptw_pkg::DEF_MAX_LEVELS,
    parameter int MAX_LEVEL_BITS = rptw_pkg::DEF_MAX_LEVEL_BITS,
    parameter int NODE_POOL      = rptw_pkg::DEF_NODE_POOL,
    parameter int FRAME_BITS     = rptw_pkg::DEF_FRAME_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rptw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rptw_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rptw_pkg::VA_W-1:0]           virtual_address,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic                                inserted,
    output logic                                frames_exhausted,
    output logic                                pool_full,
    output logic [rptw_pkg::FRAME_OUT_W-1:0]    frame_number,
    output logic [rptw_pkg::VA_W-1:0]           physical_address,
    output logic [rptw_pkg::CNT_W-1:0]          hit_count,
    output logic [rptw_pkg::CNT_W-1:0]          fault_count
);

    localparam int LEVELS    = (MAX_LEVELS < rptw_pkg::CFG_LEVELS) ? MAX_LEVELS
                                                                   : rptw_pkg::CFG_LEVELS;
    localparam int LVL_W     = $clog2(LEVELS + 1);
    localparam int SEL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int NODE_W    = $clog2(NODE_POOL);
    localparam int ALLOC_W   = $clog2(NODE_POOL + 1);
    localparam int ADDR_W    = NODE_W + MAX_LEVEL_BITS;
    localparam int DEPTH     = NODE_POOL << MAX_LEVEL_BITS;
    localparam int WORD_W    = FRAME_BITS + NODE_W + 2;
    localparam int LV_BIT    = FRAME_BITS;
    localparam int CHILD_LSB = FRAME_BITS + 1;
    localparam int CV_BIT    = FRAME_BITS + 1 + NODE_W;
    localparam int VA_W      = rptw_pkg::VA_W;
    localparam int CNT_W     = rptw_pkg::CNT_W;
    localparam int OFF_W     = rptw_pkg::OFF_W;
    localparam int FL_W      = rptw_pkg::FL_W;
    localparam int FO_W      = rptw_pkg::FRAME_OUT_W;

    // Configuration
    logic [rptw_pkg::LC_W-1:0]                          level_count_reg;
    logic [rptw_pkg::CFG_LEVELS-1:0][rptw_pkg::LB_W-1:0] level_bits_reg;
    logic [FL_W-1:0]                                    frame_limit_reg;

    // Address split
    logic [LEVELS-1:0][MAX_LEVEL_BITS-1:0] split_idx;
    logic [OFF_W-1:0]                      split_off;
    logic [LVL_W-1:0]                      split_n;

    // Walk state
    rptw_pkg::state_t                      state_reg, state_next;
    logic [ADDR_W-1:0]                     clr_addr_reg, clr_addr_next;
    logic [VA_W-1:0]                       va_reg, va_next;
    logic [LEVELS-1:0][MAX_LEVEL_BITS-1:0] idx_reg, idx_next;
    logic [OFF_W-1:0]                      off_reg, off_next;
    logic [LVL_W-1:0]                      n_reg, n_next;
    logic [LVL_W-1:0]                      lvl_reg, lvl_next;
    logic [NODE_W-1:0]                     node_reg, node_next;
    logic [WORD_W-1:0]                     word_reg, word_next;
    logic [FRAME_BITS-1:0]                 frame_reg, frame_next;
    logic                                  hit_reg, hit_next;
    logic                                  ins_reg, ins_next;
    logic                                  exh_reg, exh_next;
    logic                                  pool_reg, pool_next;
    logic [FL_W-1:0]                       frames_used_reg, frames_used_next;
    logic [ALLOC_W-1:0]                    nodes_alloc_reg, nodes_alloc_next;
    logic [CNT_W-1:0]                      hits_reg, hits_next;
    logic [CNT_W-1:0]                      faults_reg, faults_next;

    // Result register
    logic                                  out_valid_reg, out_valid_next;
    logic                                  out_hit_reg, out_hit_next;
    logic                                  out_ins_reg, out_ins_next;
    logic                                  out_exh_reg, out_exh_next;
    logic                                  out_pool_reg, out_pool_next;
    logic [FO_W-1:0]                       out_frame_reg, out_frame_next;
    logic [VA_W-1:0]                       out_pa_reg, out_pa_next;
    logic [CNT_W-1:0]                      out_hits_reg, out_hits_next;
    logic [CNT_W-1:0]                      out_faults_reg, out_faults_next;

    // Entry store: {child valid, child node, leaf valid, leaf frame}
    logic [WORD_W-1:0]                     mem [0:DEPTH-1];
    logic [WORD_W-1:0]                     rd_data_reg;
    logic                                  mem_we;
    logic [ADDR_W-1:0]                     mem_waddr;
    logic [WORD_W-1:0]                     mem_wdata;
    logic [ADDR_W-1:0]                     mem_raddr;

    logic [MAX_LEVEL_BITS-1:0]             cur_idx;
    logic [ADDR_W-1:0]                     cur_addr;
    logic                                  is_last;
    logic [LVL_W-1:0]                      need;
    logic                                  in_xfer;
    logic                                  out_free;
    logic [VA_W-1:0]                       pa_calc;

    rptw_split #(
        .LEVELS         (LEVELS),
        .MAX_LEVEL_BITS (MAX_LEVEL_BITS)
    ) u_split (
        .va          (virtual_address),
        .level_count (level_count_reg),
        .level_bits  (level_bits_reg),
        .idx         (split_idx),
        .offset      (split_off),
        .n           (split_n)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= rptw_pkg::RST_LEVEL_COUNT;
            level_bits_reg  <= {rptw_pkg::CFG_LEVELS{rptw_pkg::RST_LEVEL_BITS}};
            frame_limit_reg <= rptw_pkg::RST_FRAME_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rptw_pkg::REG_LEVEL_COUNT: level_count_reg   <= cfg_data[rptw_pkg::LC_W-1:0];
                rptw_pkg::REG_BITS_ZERO:   level_bits_reg[0] <= cfg_data[rptw_pkg::LB_W-1:0];
                rptw_pkg::REG_BITS_ONE:    level_bits_reg[1] <= cfg_data[rptw_pkg::LB_W-1:0];
                rptw_pkg::REG_BITS_TWO:    level_bits_reg[2] <= cfg_data[rptw_pkg::LB_W-1:0];
                rptw_pkg::REG_FRAME_LIMIT: frame_limit_reg   <= cfg_data[FL_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign cur_idx  = idx_reg[lvl_reg[SEL_W-1:0]];
    assign cur_addr = {node_reg, cur_idx};
    assign is_last  = (lvl_reg == n_reg - LVL_W'(1));
    assign need     = n_reg - LVL_W'(1) - lvl_reg;
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign pa_calc  = (VA_W'(frame_reg) << off_reg) | (va_reg & ~({VA_W{1'b1}} << off_reg));

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        va_next          = va_reg;
        idx_next         = idx_reg;
        off_next         = off_reg;
        n_next           = n_reg;
        lvl_next         = lvl_reg;
        node_next        = node_reg;
        word_next        = word_reg;
        frame_next       = frame_reg;
        hit_next         = hit_reg;
        ins_next         = ins_reg;
        exh_next         = exh_reg;
        pool_next        = pool_reg;
        frames_used_next = frames_used_reg;
        nodes_alloc_next = nodes_alloc_reg;
        hits_next        = hits_reg;
        faults_next      = faults_reg;

        out_valid_next   = out_valid_reg && out_stall;
        out_hit_next     = out_hit_reg;
        out_ins_next     = out_ins_reg;
        out_exh_next     = out_exh_reg;
        out_pool_next    = out_pool_reg;
        out_frame_next   = out_frame_reg;
        out_pa_next      = out_pa_reg;
        out_hits_next    = out_hits_reg;
        out_faults_next  = out_faults_reg;

        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = word_reg;
        mem_raddr = cur_addr;
        in_stall  = (state_reg != rptw_pkg::ST_IDLE);

        unique case (state_reg)
            rptw_pkg::ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = rptw_pkg::ST_IDLE;
                end
            end

            rptw_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    va_next    = virtual_address;
                    idx_next   = split_idx;
                    off_next   = split_off;
                    n_next     = split_n;
                    lvl_next   = '0;
                    node_next  = '0;
                    hit_next   = 1'b0;
                    ins_next   = 1'b0;
                    exh_next   = 1'b0;
                    pool_next  = 1'b0;
                    state_next = rptw_pkg::ST_READ;
                end
            end

            rptw_pkg::ST_READ:
            begin
                state_next = rptw_pkg::ST_EVAL;
            end

            rptw_pkg::ST_EVAL:
            begin
                if (!is_last && rd_data_reg[CV_BIT])
                begin
                    // Descend into the child node
                    node_next  = rd_data_reg[CHILD_LSB +: NODE_W];
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = rptw_pkg::ST_READ;
                end
                else if (is_last && rd_data_reg[LV_BIT])
                begin
                    hit_next   = 1'b1;
                    frame_next = rd_data_reg[FRAME_BITS-1:0];
                    hits_next  = hits_reg + CNT_W'(1);
                    state_next = rptw_pkg::ST_RESULT;
                end
                else
                begin
                    faults_next = faults_reg + CNT_W'(1);
                    word_next   = rd_data_reg;
                    if (frames_used_reg >= frame_limit_reg)
                    begin
                        exh_next   = 1'b1;
                        state_next = rptw_pkg::ST_RESULT;
                    end
                    else if ((ALLOC_W + 1)'(nodes_alloc_reg) + (ALLOC_W + 1)'(need)
                             > (ALLOC_W + 1)'(NODE_POOL))
                    begin
                        pool_next  = 1'b1;
                        state_next = rptw_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = rptw_pkg::ST_WRITE;
                    end
                end
            end

            rptw_pkg::ST_WRITE:
            begin
                mem_we = 1'b1;
                // Fresh nodes are still clear from the sweep, so only the
                // entry found missing keeps its other half
                word_next = '0;
                if (!is_last)
                begin
                    mem_wdata[CV_BIT]                = 1'b1;
                    mem_wdata[CHILD_LSB +: NODE_W]   = NODE_W'(nodes_alloc_reg);
                    node_next        = NODE_W'(nodes_alloc_reg);
                    nodes_alloc_next = nodes_alloc_reg + ALLOC_W'(1);
                    lvl_next         = lvl_reg + LVL_W'(1);
                end
                else
                begin
                    mem_wdata[LV_BIT]           = 1'b1;
                    mem_wdata[FRAME_BITS-1:0]   = FRAME_BITS'(frames_used_reg);
                    frame_next       = FRAME_BITS'(frames_used_reg);
                    frames_used_next = frames_used_reg + FL_W'(1);
                    ins_next         = 1'b1;
                    state_next       = rptw_pkg::ST_RESULT;
                end
            end

            rptw_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_hit_next    = hit_reg;
                    out_ins_next    = ins_reg;
                    out_exh_next    = exh_reg;
                    out_pool_next   = pool_reg;
                    out_frame_next  = (hit_reg || ins_reg) ? FO_W'(frame_reg) : '0;
                    out_pa_next     = (hit_reg || ins_reg) ? pa_calc : '0;
                    out_hits_next   = hits_reg;
                    out_faults_next = faults_reg;
                    state_next      = rptw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rptw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rptw_pkg::ST_CLEAR;
            clr_addr_reg    <= '0;
            lvl_reg         <= '0;
            n_reg           <= LVL_W'(1);
            node_reg        <= '0;
            hit_reg         <= 1'b0;
            ins_reg         <= 1'b0;
            exh_reg         <= 1'b0;
            pool_reg        <= 1'b0;
            frames_used_reg <= '0;
            nodes_alloc_reg <= ALLOC_W'(1);
            hits_reg        <= '0;
            faults_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            lvl_reg         <= lvl_next;
            n_reg           <= n_next;
            node_reg        <= node_next;
            hit_reg         <= hit_next;
            ins_reg         <= ins_next;
            exh_reg         <= exh_next;
            pool_reg        <= pool_next;
            frames_used_reg <= frames_used_next;
            nodes_alloc_reg <= nodes_alloc_next;
            hits_reg        <= hits_next;
            faults_reg      <= faults_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg         <= va_next;
        idx_reg        <= idx_next;
        off_reg        <= off_next;
        word_reg       <= word_next;
        frame_reg      <= frame_next;
        out_hit_reg    <= out_hit_next;
        out_ins_reg    <= out_ins_next;
        out_exh_reg    <= out_exh_next;
        out_pool_reg   <= out_pool_next;
        out_frame_reg  <= out_frame_next;
        out_pa_reg     <= out_pa_next;
        out_hits_reg   <= out_hits_next;
        out_faults_reg <= out_faults_next;
    end

    assign out_valid        = out_valid_reg;
    assign hit              = out_hit_reg;
    assign inserted         = out_ins_reg;
    assign frames_exhausted = out_exh_reg;
    assign pool_full        = out_pool_reg;
    assign frame_number     = out_frame_reg;
    assign physical_address = out_pa_reg;
    assign hit_count        = out_hits_reg;
    assign fault_count      = out_faults_reg;

`ifndef SYNTH
    // The pool never hands out more nodes than it holds
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nodes_alloc_reg <= ALLOC_W'(NODE_POOL))
        else $error("node pool count beyond pool size");

    // Table writes only land in nodes already taken from the pool
    a_write_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == rptw_pkg::ST_WRITE) |-> (ALLOC_W'(node_reg) < nodes_alloc_reg))
        else $error("table write to an unallocated node");

    // A new result appears only from the result state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rptw_pkg::ST_RESULT))
        else $error("result posted outside the result state");

    // At most one outcome per result, and a result with none carries frame zero
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot({out_hit_reg, out_ins_reg, out_exh_reg, out_pool_reg})
                          || !(out_hit_reg || out_ins_reg || out_exh_reg || out_pool_reg)
                             && (out_frame_reg == '0))
        else $error("result carries conflicting outcome flags");
`endif

endmodule

@@ tb/radix_page_table_walker_tb.sv @@
// ----------------------------------------------------------------------------
// radix_page_table_walker_tb
// Self-checking bench for the radix page table walker. A directed table covers
// the reset geometry, one-level and saturated widths, frame exhaustion and a
// return to defaults. Random phases then reconfigure the walker and replay a
// mix of repeated pages, clustered pages and scattered addresses, 62 items in
// each of eight phases. Each result is checked against an in-bench table model
// or, for checked rows, against the expectation given in the row.
module radix_page_table_walker_tb;

    localparam int VA_W               = rptw_pkg::VA_W;
    localparam int CNT_W              = rptw_pkg::CNT_W;
    localparam int FRAME_OUT_W        = rptw_pkg::FRAME_OUT_W;
    localparam int CFG_IDX_W          = rptw_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W         = rptw_pkg::CFG_DATA_W;
    localparam int LC_W               = rptw_pkg::LC_W;
    localparam int LB_W               = rptw_pkg::LB_W;
    localparam int FL_W               = rptw_pkg::FL_W;
    localparam int DEF_MAX_LEVELS     = rptw_pkg::DEF_MAX_LEVELS;
    localparam int DEF_MAX_LEVEL_BITS = rptw_pkg::DEF_MAX_LEVEL_BITS;

    localparam int POOL          = rptw_pkg::DEF_NODE_POOL;
    localparam int SPAN          = 1 << DEF_MAX_LEVEL_BITS;
    localparam int DEPTH         = POOL * SPAN;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 62;
    localparam int DRAIN_CYCLES  = 16;
    localparam int WATCHDOG      = 60000;

    typedef struct packed {
        logic                    hit;
        logic                    inserted;
        logic                    frames_exhausted;
        logic                    pool_full;
        logic [FRAME_OUT_W-1:0]  frame_number;
        logic [VA_W-1:0]         physical_address;
        logic [CNT_W-1:0]        hit_count;
        logic [CNT_W-1:0]        fault_count;
    } walk_result_t;

    typedef struct packed {
        logic                    is_cfg;
        logic [CFG_IDX_W-1:0]    reg_index;
        logic [VA_W-1:0]         value;
        logic                    typed;
        walk_result_t            want;
    } directed_row_t;

    typedef enum int { FLOW, COIN, HEAVY, PERIODIC } stall_mode_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [VA_W-1:0]         virtual_address = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    hit;
    logic                    inserted;
    logic                    frames_exhausted;
    logic                    pool_full;
    logic [FRAME_OUT_W-1:0]  frame_number;
    logic [VA_W-1:0]         physical_address;
    logic [CNT_W-1:0]        hit_count;
    logic [CNT_W-1:0]        fault_count;

    // Table model state
    logic [6:0]              node_link [DEPTH];
    bit                      link_ok [DEPTH];
    bit                      leaf_ok [DEPTH];
    logic [FRAME_OUT_W-1:0]  leaf_frame [DEPTH];
    int unsigned             nodes_taken = 1;
    int unsigned             frames_taken = 0;
    logic [CNT_W-1:0]        hits_seen = '0;
    logic [CNT_W-1:0]        faults_seen = '0;

    // Shadow of the configuration registers
    logic [LC_W-1:0]         cfg_levels = rptw_pkg::RST_LEVEL_COUNT;
    logic [LB_W-1:0]         cfg_bits [3] = '{rptw_pkg::RST_LEVEL_BITS,
                                              rptw_pkg::RST_LEVEL_BITS,
                                              rptw_pkg::RST_LEVEL_BITS};
    logic [FL_W-1:0]         cfg_frame_limit = rptw_pkg::RST_FRAME_LIMIT;

    walk_result_t            expected_walks [$];
    directed_row_t           directed_rows [$];
    logic [VA_W-1:0]         recent_pages [$];
    int                      mismatches = 0;
    int                      burst_left = 0;
    stall_mode_t             stall_mode = FLOW;
    int                      mode_left = 0;
    int unsigned             stall_tick = 0;

    radix_page_table_walker dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .virtual_address  (virtual_address),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .hit              (hit),
        .inserted         (inserted),
        .frames_exhausted (frames_exhausted),
        .pool_full        (pool_full),
        .frame_number     (frame_number),
        .physical_address (physical_address),
        .hit_count        (hit_count),
        .fault_count      (fault_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    // Walk the table for one address, updating the model as the block would
    function automatic walk_result_t translate_address(input logic [VA_W-1:0] va);
        int unsigned  levels;
        int unsigned  remaining;
        int unsigned  w;
        int unsigned  idx [3];
        int unsigned  node;
        int unsigned  stop;
        int unsigned  a;
        int unsigned  fresh;
        int unsigned  i;
        int unsigned  j;
        logic [63:0]  wide;
        logic [63:0]  pa_wide;
        logic [FRAME_OUT_W-1:0] frame;
        walk_result_t r;

        r = '0;
        frame = '0;
        idx = '{0, 0, 0};
        wide = {32'd0, va};
        levels = cfg_levels;
        if (levels < 1)
            levels = 1;
        if (levels > ((DEF_MAX_LEVELS < 3) ? DEF_MAX_LEVELS : 3))
            levels = (DEF_MAX_LEVELS < 3) ? DEF_MAX_LEVELS : 3;

        remaining = 32;
        for (i = 0; i < levels; i++)
        begin
            w = cfg_bits[i];
            if (w < 1)
                w = 1;
            if (w > DEF_MAX_LEVEL_BITS)
                w = DEF_MAX_LEVEL_BITS;
            if (w > remaining)
                w = remaining;
            remaining -= w;
            idx[i] = (w == 0) ? 0 : int'((wide >> remaining) & ((64'd1 << w) - 64'd1));
        end

        node = 0;
        stop = levels - 1;
        for (i = 0; i + 1 < levels; i++)
        begin
            a = node * SPAN + idx[i];
            if (!link_ok[a] || node_link[a] >= POOL)
            begin
                stop = i;
                break;
            end
            node = node_link[a];
        end

        if (stop == levels - 1)
        begin
            a = node * SPAN + idx[levels - 1];
            if (leaf_ok[a])
            begin
                r.hit = 1'b1;
                frame = leaf_frame[a];
            end
        end

        if (r.hit)
            hits_seen++;
        else
        begin
            faults_seen++;
            if (frames_taken >= cfg_frame_limit)
                r.frames_exhausted = 1'b1;
            else if (nodes_taken + (levels - 1 - stop) > POOL)
                r.pool_full = 1'b1;
            else
            begin
                for (i = stop; i + 1 < levels; i++)
                begin
                    fresh = nodes_taken++;
                    for (j = 0; j < SPAN; j++)
                    begin
                        node_link[fresh * SPAN + j] = '0;
                        link_ok[fresh * SPAN + j] = 1'b0;
                        leaf_ok[fresh * SPAN + j] = 1'b0;
                        leaf_frame[fresh * SPAN + j] = '0;
                    end
                    a = node * SPAN + idx[i];
                    node_link[a] = fresh[6:0];
                    link_ok[a] = 1'b1;
                    node = fresh;
                end
                frame = frames_taken[FRAME_OUT_W-1:0];
                a = node * SPAN + idx[levels - 1];
                leaf_ok[a] = 1'b1;
                leaf_frame[a] = frame;
                frames_taken++;
                r.inserted = 1'b1;
            end
        end

        if (r.hit || r.inserted)
        begin
            pa_wide = ({48'd0, frame} << remaining) | (wide & ((64'd1 << remaining) - 64'd1));
            r.frame_number = frame;
            r.physical_address = pa_wide[31:0];
        end
        r.hit_count = hits_seen;
        r.fault_count = faults_seen;
        return r;
    endfunction

    function automatic directed_row_t address_row(input logic [VA_W-1:0] va);
        directed_row_t row;
        row = '0;
        row.value = va;
        return row;
    endfunction

    function automatic directed_row_t checked_row(input logic [VA_W-1:0] va,
                                                  input walk_result_t want);
        directed_row_t row;
        row = '0;
        row.value = va;
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic directed_row_t register_row(input logic [CFG_IDX_W-1:0] idx,
                                                   input logic [VA_W-1:0] data);
        directed_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.reg_index = idx;
        row.value = data;
        return row;
    endfunction

    // Send one address; the expectation is queued on the transfer edge
    task automatic transfer_address(input logic [VA_W-1:0] va, input bit typed,
                                    input walk_result_t want);
        int gap;
        walk_result_t predicted;

        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        virtual_address <= va;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = translate_address(va);
        expected_walks.push_back(typed ? want : predicted);
    endtask

    // Drop valid and wait until every result has come back
    task automatic await_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_walks.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            rptw_pkg::REG_LEVEL_COUNT: cfg_levels = data[LC_W-1:0];
            rptw_pkg::REG_BITS_ZERO:   cfg_bits[0] = data[LB_W-1:0];
            rptw_pkg::REG_BITS_ONE:    cfg_bits[1] = data[LB_W-1:0];
            rptw_pkg::REG_BITS_TWO:    cfg_bits[2] = data[LB_W-1:0];
            rptw_pkg::REG_FRAME_LIMIT: cfg_frame_limit = data[FL_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        walk_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_walks.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                mismatches++;
            end
            else
            begin
                want = expected_walks.pop_front();
                compare_field("hit", 32'(want.hit), 32'(hit));
                compare_field("inserted", 32'(want.inserted), 32'(inserted));
                compare_field("frames_exhausted", 32'(want.frames_exhausted),
                              32'(frames_exhausted));
                compare_field("pool_full", 32'(want.pool_full), 32'(pool_full));
                compare_field("frame_number", 32'(want.frame_number), 32'(frame_number));
                compare_field("physical_address", want.physical_address, physical_address);
                compare_field("hit_count", want.hit_count, hit_count);
                compare_field("fault_count", want.fault_count, fault_count);
            end
        end
    end

    // Receiver back-pressure: switch between patterns every so often
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        stall_tick++;
        case (stall_mode)
            FLOW:     out_stall <= 1'b0;
            COIN:     out_stall <= ($urandom_range(0, 1) == 1);
            HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            PERIODIC: out_stall <= ((stall_tick % 5) < 2);
            default:  out_stall <= 1'b0;
        endcase
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int               p;
        int               i;
        int               pick;
        int unsigned      lim;
        logic [VA_W-1:0]  va;

        directed_rows = '{
            // reset geometry: two levels of eight bits, 16-bit offset
            checked_row(32'h0000_0000, '{1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 32'h0000_0000,
                                         32'd0, 32'd1}),
            checked_row(32'h0000_FFFF, '{1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_FFFF,
                                         32'd1, 32'd1}),
            checked_row(32'hFFFF_FFFF, '{1'b0, 1'b1, 1'b0, 1'b0, 16'h0001, 32'h0001_FFFF,
                                         32'd1, 32'd2}),
            checked_row(32'hFFFF_0000, '{1'b1, 1'b0, 1'b0, 1'b0, 16'h0001, 32'h0001_0000,
                                         32'd2, 32'd2}),
            address_row(32'h00FF_1234),
            // zero level count and zero width both fall back to one
            register_row(rptw_pkg::REG_LEVEL_COUNT, 32'd0),
            register_row(rptw_pkg::REG_BITS_ZERO, 32'd0),
            address_row(32'h8000_0000),
            address_row(32'h7FFF_FFFF),
            address_row(32'hC000_0000),
            // oversized widths saturate to eight bits
            register_row(rptw_pkg::REG_LEVEL_COUNT, 32'd3),
            register_row(rptw_pkg::REG_BITS_ZERO, 32'd15),
            register_row(rptw_pkg::REG_BITS_ONE, 32'd15),
            register_row(rptw_pkg::REG_BITS_TWO, 32'd15),
            address_row(32'h1234_5678),
            address_row(32'h1234_56FF),
            address_row(32'hFFFF_FF00),
            address_row(32'h0000_0000),
            register_row(rptw_pkg::REG_BITS_ONE, 32'd1),
            register_row(rptw_pkg::REG_BITS_TWO, 32'd4),
            address_row(32'hA5A5_A5A5),
            address_row(32'h5A5A_5A5A),
            // no frames left to hand out
            register_row(rptw_pkg::REG_FRAME_LIMIT, 32'd0),
            address_row(32'h0BAD_F00D),
            address_row(32'h1234_5678),
            register_row(rptw_pkg::REG_FRAME_LIMIT, 32'h0000_FFFF),
            // old mappings read back with the default geometry
            register_row(rptw_pkg::REG_LEVEL_COUNT, 32'd2),
            register_row(rptw_pkg::REG_BITS_ZERO, 32'd8),
            register_row(rptw_pkg::REG_BITS_ONE, 32'd8),
            register_row(rptw_pkg::REG_BITS_TWO, 32'd8),
            address_row(32'h0000_ABCD)
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].is_cfg)
            begin
                await_idle();
                write_register(directed_rows[k].reg_index, directed_rows[k].value[15:0]);
            end
            else
                transfer_address(directed_rows[k].value, directed_rows[k].typed,
                                 directed_rows[k].want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            await_idle();
            write_register(rptw_pkg::REG_LEVEL_COUNT, 16'($urandom_range(0, 3)));
            write_register(rptw_pkg::REG_BITS_ZERO, 16'(($urandom_range(0, 9) == 0) ?
                           $urandom_range(9, 15) : $urandom_range(0, 8)));
            write_register(rptw_pkg::REG_BITS_ONE, 16'(($urandom_range(0, 9) == 0) ?
                           $urandom_range(9, 15) : $urandom_range(0, 8)));
            write_register(rptw_pkg::REG_BITS_TWO, 16'(($urandom_range(0, 9) == 0) ?
                           $urandom_range(9, 15) : $urandom_range(0, 8)));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                lim = 0;
            else if (pick < 3)
                lim = frames_taken + $urandom_range(0, 24);
            else if (pick == 3)
                lim = $urandom_range(0, 65535);
            else
                lim = 65535;
            if (lim > 65535)
                lim = 65535;
            write_register(rptw_pkg::REG_FRAME_LIMIT, lim[15:0]);

            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5 && recent_pages.size() > 0)
                    // same page, different offset: a hit unless the geometry moved or the page was never mapped
                    va = recent_pages[$urandom_range(0, recent_pages.size() - 1)]
                         ^ ($urandom & 32'h0000_00FF);
                else if (pick < 8)
                    va = {(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 3))),
                          24'($urandom)};
                else
                    va = $urandom;
                if (recent_pages.size() < 32)
                    recent_pages.push_back(va);
                else
                    recent_pages[$urandom_range(0, 31)] = va;
                transfer_address(va, 1'b0, '0);
            end
        end

        await_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_walks.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
